@@ sv/kdar_pkg.sv @@
// Package for the key debounce and auto-repeat core.
// Holds the switch phase encoding, event kinds, register indexes and shared structs.
// No dependencies.
`default_nettype none

package kdar_pkg;

   typedef enum logic [7:0] {
      PH_IDLE             = 8'b0000_0001,
      PH_NEGATED          = 8'b0000_0010,
      PH_DEB_ASSERT       = 8'b0000_0100,
      PH_ASSERTED         = 8'b0000_1000,
      PH_DEB_NEGATE       = 8'b0001_0000,
      PH_HELD             = 8'b0010_0000,
      PH_HELD_FAST        = 8'b0100_0000,
      PH_DEB_RELEASE_HELD = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      EV_RELEASED      = 2'd0,
      EV_REPEAT        = 2'd1,
      EV_HELD_START    = 2'd2,
      EV_HELD_RELEASED = 2'd3
   } event_kind_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNCE_LIMIT        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_REPEAT_GAP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_REPEAT_GAP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEATS_BEFORE_FAST = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_ENABLE        = 3'd4;

   localparam logic [15:0] BOUNCE_LIMIT_RESET        = 16'd20;
   localparam logic [15:0] SLOW_REPEAT_GAP_RESET     = 16'd250;
   localparam logic [15:0] FAST_REPEAT_GAP_RESET     = 16'd20;
   localparam logic [7:0]  REPEATS_BEFORE_FAST_RESET = 8'd10;
   localparam logic [3:0]  EVENT_ENABLE_RESET        = 4'hF;

   typedef struct packed {
      logic [15:0] bounce_limit;
      logic [15:0] slow_repeat_gap;
      logic [15:0] fast_repeat_gap;
      logic [7:0]  repeats_before_fast;
      logic [3:0]  event_enable;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] bounce_word;
      logic [31:0] start_stamp;
      logic [7:0]  repeat_count;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      phase:        PH_IDLE,
      bounce_word:  32'd0,
      start_stamp:  32'd0,
      repeat_count: 8'd0
   };

   typedef struct packed {
      logic           have;
      event_kind_type kind;
   } event_type;

endpackage

`default_nettype wire

@@ sv/kdar_csr.sv @@
// Configuration registers of the key debounce and auto-repeat core.
// Depends on kdar_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module kdar_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [kdar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kdar_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output kdar_pkg::cfg_type                       cfg
);

   kdar_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_limit        <= kdar_pkg::BOUNCE_LIMIT_RESET;
         cfg_ff.slow_repeat_gap     <= kdar_pkg::SLOW_REPEAT_GAP_RESET;
         cfg_ff.fast_repeat_gap     <= kdar_pkg::FAST_REPEAT_GAP_RESET;
         cfg_ff.repeats_before_fast <= kdar_pkg::REPEATS_BEFORE_FAST_RESET;
         cfg_ff.event_enable        <= kdar_pkg::EVENT_ENABLE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            kdar_pkg::CSR_BOUNCE_LIMIT:        cfg_ff.bounce_limit <= csr_write_data;
            kdar_pkg::CSR_SLOW_REPEAT_GAP:     cfg_ff.slow_repeat_gap <= csr_write_data;
            kdar_pkg::CSR_FAST_REPEAT_GAP:     cfg_ff.fast_repeat_gap <= csr_write_data;
            kdar_pkg::CSR_REPEATS_BEFORE_FAST: cfg_ff.repeats_before_fast <= csr_write_data[7:0];
            kdar_pkg::CSR_EVENT_ENABLE:        cfg_ff.event_enable <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/kdar_step.sv @@
// Next-state and event logic for one switch sample.
// Depends on kdar_pkg for the phase encoding, entry_type, cfg_type and event_type.
`default_nettype none

module kdar_step (
   input  wire kdar_pkg::entry_type cur,
   input  wire logic             pressed,
   input  wire logic [31:0]      tick_now,
   input  wire kdar_pkg::cfg_type cfg,
   output kdar_pkg::entry_type   nxt,
   output kdar_pkg::event_type   evt
);

   logic [31:0] bounce_diff;
   logic [31:0] start_diff;
   logic [31:0] bounce_inc;
   logic [31:0] limit_ext;
   logic [31:0] slow_ext;
   logic [31:0] fast_ext;
   logic [7:0]  count_inc;

   assign bounce_diff = tick_now - cur.bounce_word;
   assign start_diff  = tick_now - cur.start_stamp;
   assign bounce_inc  = cur.bounce_word + 32'd1;
   assign limit_ext   = {16'd0, cfg.bounce_limit};
   assign slow_ext    = {16'd0, cfg.slow_repeat_gap};
   assign fast_ext    = {16'd0, cfg.fast_repeat_gap};
   assign count_inc   = cur.repeat_count + 8'd1;

   always_comb begin
      nxt      = cur;
      evt.have = 1'b0;
      evt.kind = kdar_pkg::EV_RELEASED;
      unique case (cur.phase)
         kdar_pkg::PH_IDLE: begin
            nxt.phase = kdar_pkg::PH_NEGATED;
         end
         kdar_pkg::PH_NEGATED: begin
            if (pressed) begin
               nxt.bounce_word = tick_now;
               nxt.phase       = kdar_pkg::PH_DEB_ASSERT;
            end
         end
         kdar_pkg::PH_DEB_ASSERT: begin
            if (!pressed) begin
               nxt.phase = kdar_pkg::PH_NEGATED;
            end else if (bounce_diff > limit_ext) begin
               nxt.bounce_word = tick_now;
               nxt.phase       = kdar_pkg::PH_ASSERTED;
            end
         end
         kdar_pkg::PH_ASSERTED: begin
            if (!pressed) begin
               nxt.bounce_word = 32'd0;
               nxt.phase       = kdar_pkg::PH_DEB_NEGATE;
            end else if (bounce_diff > limit_ext) begin
               evt.have         = cfg.event_enable[kdar_pkg::EV_HELD_START];
               evt.kind         = kdar_pkg::EV_HELD_START;
               nxt.start_stamp  = tick_now;
               nxt.repeat_count = 8'd0;
               nxt.phase        = kdar_pkg::PH_HELD;
            end
         end
         kdar_pkg::PH_DEB_NEGATE: begin
            if (pressed) begin
               nxt.start_stamp = 32'd0;
               nxt.phase       = kdar_pkg::PH_ASSERTED;
            end else begin
               nxt.bounce_word = bounce_inc;
               if (bounce_inc > limit_ext) begin
                  evt.have  = cfg.event_enable[kdar_pkg::EV_RELEASED];
                  evt.kind  = kdar_pkg::EV_RELEASED;
                  nxt.phase = kdar_pkg::PH_NEGATED;
               end
            end
         end
         kdar_pkg::PH_HELD: begin
            if (!pressed) begin
               nxt.bounce_word = 32'd0;
               nxt.phase       = kdar_pkg::PH_DEB_RELEASE_HELD;
            end else if (start_diff > slow_ext) begin
               evt.have         = cfg.event_enable[kdar_pkg::EV_REPEAT];
               evt.kind         = kdar_pkg::EV_REPEAT;
               nxt.start_stamp  = tick_now;
               nxt.repeat_count = count_inc;
               if (count_inc > cfg.repeats_before_fast) begin
                  nxt.phase = kdar_pkg::PH_HELD_FAST;
               end
            end
         end
         kdar_pkg::PH_HELD_FAST: begin
            if (!pressed) begin
               nxt.bounce_word = 32'd0;
               nxt.phase       = kdar_pkg::PH_DEB_RELEASE_HELD;
            end else if (start_diff > fast_ext) begin
               if (cfg.event_enable[kdar_pkg::EV_REPEAT]) begin
                  evt.have        = 1'b1;
                  evt.kind        = kdar_pkg::EV_REPEAT;
                  nxt.start_stamp = tick_now;
               end
            end
         end
         kdar_pkg::PH_DEB_RELEASE_HELD: begin
            if (pressed) begin
               if (cur.repeat_count >= cfg.repeats_before_fast) begin
                  nxt.phase = kdar_pkg::PH_HELD_FAST;
               end else begin
                  nxt.phase = kdar_pkg::PH_HELD;
               end
               nxt.start_stamp = cur.start_stamp + cur.bounce_word;
            end else begin
               nxt.bounce_word = bounce_inc;
               if (bounce_inc > limit_ext) begin
                  evt.have  = cfg.event_enable[kdar_pkg::EV_HELD_RELEASED];
                  evt.kind  = kdar_pkg::EV_HELD_RELEASED;
                  nxt.phase = kdar_pkg::PH_NEGATED;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/key_debounce_autorepeat_core.sv @@
// Key debounce and auto-repeat core with an input register and a result register.
// Throughput is one item per cycle unless a stalled result holds the input stage; the per-switch
// state registers are read, updated and written back between the input and result registers.
// Reset is synchronous and active high: every switch returns to idle with cleared
// state, and the configuration registers return to their defaults.
// Depends on kdar_pkg, kdar_csr and kdar_step.
`default_nettype none

module key_debounce_autorepeat_core #(
   parameter int NUM_SWITCHES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [2:0]                         req_switch_index,
   input  wire logic                               req_pin_level,
   input  wire logic [31:0]                        req_tick_now,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [2:0]                         rsp_event_switch,
   output      logic [1:0]                         rsp_event_kind,
   input  wire logic                               csr_write_enable,
   input  wire logic [kdar_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kdar_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

   kdar_pkg::cfg_type   cfg;
   kdar_pkg::entry_type entry_ff [NUM_SWITCHES];
   kdar_pkg::entry_type cur_entry;
   kdar_pkg::entry_type nxt_entry;
   kdar_pkg::event_type evt;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [2:0]  s1_switch_index_ff;
   logic        s1_pin_level_ff;
   logic [31:0] s1_tick_now_ff;
   logic [31:0] s1_index_ext;
   logic        s1_in_range;
   logic [IDX_W-1:0] s1_slot;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  rsp_event_switch_ff;
   logic [1:0]  rsp_event_kind_ff;

   logic        rsp_hold;
   logic        advance;
   logic        req_take;

   kdar_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign s1_index_ext = {29'd0, s1_switch_index_ff};
   assign s1_in_range  = s1_index_ext < NUM_SWITCHES;
   assign s1_slot      = s1_index_ext[IDX_W-1:0];
   assign cur_entry    = s1_in_range ? entry_ff[s1_slot] : kdar_pkg::ENTRY_RESET;

   kdar_step u_step (
      .cur      (cur_entry),
      .pressed  (!s1_pin_level_ff),
      .tick_now (s1_tick_now_ff),
      .cfg      (cfg),
      .nxt      (nxt_entry),
      .evt      (evt)
   );

   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign advance   = s1_valid_ff && !rsp_hold;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (rsp_hold) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = advance && s1_in_range && evt.have;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_switch_index_ff <= req_switch_index;
         s1_pin_level_ff    <= req_pin_level;
         s1_tick_now_ff     <= req_tick_now;
      end
      if (advance && s1_in_range && evt.have) begin
         rsp_event_switch_ff <= s1_switch_index_ff;
         rsp_event_kind_ff   <= evt.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            entry_ff[i] <= kdar_pkg::ENTRY_RESET;
         end
      end else if (advance && s1_in_range) begin
         entry_ff[s1_slot] <= nxt_entry;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_switch = rsp_event_switch_ff;
   assign rsp_event_kind   = rsp_event_kind_ff;

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty stage");

   a_phase_onehot : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_in_range) |-> $onehot(cur_entry.phase))
      else $error("switch phase is not one-hot");

   a_out_of_range_silent : assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_in_range) |=> !rsp_valid_ff)
      else $error("out-of-range switch raised an item");

   a_rsp_switch_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({29'd0, rsp_event_switch_ff} < NUM_SWITCHES))
      else $error("result item names a switch out of range");

endmodule

`default_nettype wire
